/* rtl/core/mma_pkg.sv */
package mma_pkg;

    localparam int SAMPLE_W          = 16;
    localparam int VALUE_W           = 12;
    localparam int CH_FIELD_W        = 3;
    localparam int NUM_SAMPLE_FIELDS = 8;
    localparam int QUOT_W            = VALUE_W;
    // wide enough for a ring index at the largest supported depth (64)
    localparam int LANE_ADDR_W       = 6;

    localparam logic REQ_STORE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic                  req_type;
        logic [SAMPLE_W-1:0]   sample_ch0;
        logic [SAMPLE_W-1:0]   sample_ch1;
        logic [SAMPLE_W-1:0]   sample_ch2;
        logic [SAMPLE_W-1:0]   sample_ch3;
        logic [SAMPLE_W-1:0]   sample_ch4;
        logic [SAMPLE_W-1:0]   sample_ch5;
        logic [SAMPLE_W-1:0]   sample_ch6;
        logic [SAMPLE_W-1:0]   sample_ch7;
        logic [CH_FIELD_W-1:0] query_channel;
    } t_in;

    typedef struct packed {
        logic [VALUE_W-1:0]    avg_value;
        logic [CH_FIELD_W-1:0] avg_channel;
    } t_out;

    // control broadcast to every channel lane
    typedef struct packed {
        logic                   wr_en;
        logic                   rd_en;
        logic [LANE_ADDR_W-1:0] addr;
        logic                   acc_clr;
        logic                   acc_en;
        logic                   acc_row_valid;
    } t_lane_ctrl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_LAST,
        ST_LOAD,
        ST_DIV
    } t_state;

endpackage

/* rtl/core/mma_lane.sv */
module mma_lane #(
    parameter int DEPTH = 20,
    parameter int SUM_W = 17
) (
    input  logic                        i_clk,
    input  mma_pkg::t_lane_ctrl         i_ctrl,
    input  logic [mma_pkg::VALUE_W-1:0] i_sample,
    output logic [SUM_W-1:0]            o_sum
);
    import mma_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [VALUE_W-1:0] r_mem [DEPTH];
    logic [VALUE_W-1:0] r_rdata;
    logic [SUM_W-1:0]   r_acc;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[i_ctrl.addr[AW-1:0]] <= i_sample;
        end
        if (i_ctrl.rd_en) begin
            r_rdata <= r_mem[i_ctrl.addr[AW-1:0]];
        end
    end

    // rows never written since reset count as zero
    always_ff @(posedge i_clk) begin
        if (i_ctrl.acc_clr) begin
            r_acc <= '0;
        end else if (i_ctrl.acc_en && i_ctrl.acc_row_valid) begin
            r_acc <= r_acc + SUM_W'(r_rdata);
        end
    end

    assign o_sum = r_acc;

endmodule

/* rtl/core/mma_merge.sv */
module mma_merge #(
    parameter int DEPTH    = 20,
    parameter int CHANNELS = 8,
    parameter int SUM_W    = 17
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [mma_pkg::CH_FIELD_W-1:0] i_channel,
    input  logic [SUM_W-1:0]               i_lane_sum [CHANNELS],
    output logic                           o_busy,
    output logic [mma_pkg::QUOT_W-1:0]     o_quot
);
    import mma_pkg::*;

    // floor(x / DEPTH) == (x * ceil(2^SH / DEPTH)) >> SH for every x below 2^SUM_W
    localparam int              RECIP_SH = SUM_W + $clog2(DEPTH);
    localparam logic [SUM_W:0]  RECIP    = (SUM_W + 1)'(((64'd1 << RECIP_SH)
                                           + 64'(DEPTH) - 64'd1) / 64'(DEPTH));

    logic [SUM_W-1:0]  w_pad [NUM_SAMPLE_FIELDS];
    logic [2*SUM_W:0]  w_prod;
    logic              r_busy;
    logic [SUM_W-1:0]  r_sel;
    logic [QUOT_W-1:0] r_quot;

    // channels that do not exist read as an empty window
    for (genvar g = 0; g < NUM_SAMPLE_FIELDS; g++) begin : g_pad
        if (g < CHANNELS) begin : g_live
            assign w_pad[g] = i_lane_sum[g];
        end else begin : g_none
            assign w_pad[g] = '0;
        end
    end

    assign w_prod = (2*SUM_W + 1)'(r_sel) * (2*SUM_W + 1)'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= i_start;
        end
    end

    // select the lane sum, then multiply it by the reciprocal into r_quot
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sel <= w_pad[i_channel];
        end
        if (r_busy) begin
            r_quot <= w_prod[RECIP_SH +: QUOT_W];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

/* rtl/core/multichannel_moving_average.sv */
// Sequence: a store transaction returns nothing; a query returns its average after DEPTH
//   reads, add, load, multiply and output, the output waiting while a result is pending.
// Throughput: one store per cycle while no query is in flight; a query holds o_ready low through
//   the ring sweep over each lane's single read port, the reciprocal divide and the output hand-off.
// Reset: synchronous, active low; ring position and row-valid bits clear, so every
//   stored entry reads as zero until written again. No clearing pass is needed.
module multichannel_moving_average #(
    parameter int DEPTH    = 20,
    parameter int CHANNELS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  mma_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output mma_pkg::t_out o_data
);
    import mma_pkg::*;

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // window sum stays below DEPTH * 4096
    localparam int SUM_W = VALUE_W + $clog2(DEPTH + 1);

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    t_state                r_state, n_state;
    logic [AW-1:0]         r_wr_idx;     // ring slot of next store
    logic [AW-1:0]         r_rd_cnt;     // sweep address during a query
    logic [DEPTH-1:0]      r_row_valid;  // row written since reset
    logic                  r_acc_en;     // read data valid this cycle
    logic                  r_row_v;      // row-valid bit aligned with read data
    logic [CH_FIELD_W-1:0] r_q_ch;       // channel of the query in flight
    logic                  r_out_valid;
    t_out                  r_out;

    logic       w_accept;
    logic       w_store;
    logic       w_query;
    logic       w_start;
    logic       w_load_out;
    logic       w_div_busy;
    logic [QUOT_W-1:0] w_quot;
    t_lane_ctrl w_ctrl;

    logic [SAMPLE_W-1:0] w_samples  [NUM_SAMPLE_FIELDS];
    logic [SUM_W-1:0]    w_lane_sum [CHANNELS];

    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_store  = w_accept && (i_data.req_type == REQ_STORE);
    assign w_query  = w_accept && (i_data.req_type == REQ_QUERY);

    assign w_samples[0] = i_data.sample_ch0;
    assign w_samples[1] = i_data.sample_ch1;
    assign w_samples[2] = i_data.sample_ch2;
    assign w_samples[3] = i_data.sample_ch3;
    assign w_samples[4] = i_data.sample_ch4;
    assign w_samples[5] = i_data.sample_ch5;
    assign w_samples[6] = i_data.sample_ch6;
    assign w_samples[7] = i_data.sample_ch7;

    // ------------------------------------------------------------------
    // Sequencer: IDLE -> SUM (DEPTH reads) -> LAST (final add) ->
    // LOAD (divider start) -> DIV (divide, then hand to output register)
    // ------------------------------------------------------------------
    assign w_start    = (r_state == ST_LOAD);
    assign w_load_out = (r_state == ST_DIV) && !w_div_busy && (!r_out_valid || i_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_query) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                if (r_rd_cnt == AW'(DEPTH - 1)) begin
                    n_state = ST_LAST;
                end
            end
            ST_LAST: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (w_load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wr_idx    <= '0;
            r_rd_cnt    <= '0;
            r_row_valid <= '0;
            r_acc_en    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_acc_en <= w_ctrl.rd_en;
            if (w_store) begin
                r_row_valid[r_wr_idx] <= 1'b1;
                r_wr_idx <= (r_wr_idx == AW'(DEPTH - 1)) ? '0 : r_wr_idx + 1'b1;
            end
            if (w_query) begin
                r_rd_cnt <= '0;
            end else if (r_state == ST_SUM && r_rd_cnt != AW'(DEPTH - 1)) begin
                r_rd_cnt <= r_rd_cnt + 1'b1;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_row_v <= r_row_valid[r_rd_cnt];
        if (w_query) begin
            r_q_ch <= i_data.query_channel;
        end
        if (w_load_out) begin
            r_out.avg_value   <= w_quot;
            r_out.avg_channel <= r_q_ch;
        end
    end

    // ------------------------------------------------------------------
    // Lane control: a store writes every lane at the ring slot; a query
    // sweeps every lane in parallel, each summing its own channel.
    // ------------------------------------------------------------------
    always_comb begin
        w_ctrl.wr_en         = w_store;
        w_ctrl.rd_en         = (r_state == ST_SUM);
        w_ctrl.addr          = w_store ? LANE_ADDR_W'(r_wr_idx) : LANE_ADDR_W'(r_rd_cnt);
        w_ctrl.acc_clr       = w_query;
        w_ctrl.acc_en        = r_acc_en;
        w_ctrl.acc_row_valid = r_row_v;
    end

    for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
        mma_lane #(
            .DEPTH (DEPTH),
            .SUM_W (SUM_W)
        ) u_lane (
            .i_clk    (i_clk),
            .i_ctrl   (w_ctrl),
            .i_sample (w_samples[g][SAMPLE_W-1 -: VALUE_W]),
            .o_sum    (w_lane_sum[g])
        );
    end

    // Merge: pick the queried lane (zero for a missing channel), divide by DEPTH
    mma_merge #(
        .DEPTH    (DEPTH),
        .CHANNELS (CHANNELS),
        .SUM_W    (SUM_W)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_channel  (r_q_ch),
        .i_lane_sum (w_lane_sum),
        .o_busy     (w_div_busy),
        .o_quot     (w_quot)
    );

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

/* rtl/core/mma_checker.sv */
module mma_checker #(
    parameter int CHANNELS = 8
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_ready,
    input mma_pkg::t_in  i_data,
    input logic          o_valid,
    input logic          i_ready,
    input mma_pkg::t_out o_data
);
    import mma_pkg::*;

    // a pending result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed or dropped while stalled");

    // a query transaction occupies the block
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_data.req_type == REQ_QUERY |=> !o_ready)
        else $error("ready stayed high after a query");

    // a store completes in its own cycle
    a_store_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_data.req_type == REQ_STORE |=> o_ready)
        else $error("ready dropped after a store");

    // a missing channel averages to zero
    a_missing_ch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && ({1'b0, o_data.avg_channel} >= (CH_FIELD_W + 1)'(CHANNELS))
        |-> o_data.avg_value == '0)
        else $error("nonzero average for a missing channel");

endmodule

bind multichannel_moving_average mma_checker #(.CHANNELS(CHANNELS)) u_mma_checker (.*);
